>>> hdl/pfru_pkg.sv
// Shared types and codes for the page fault and replacement unit.
`timescale 1ns / 1ps

package pfru_pkg;

  localparam int MAX_FRAMES_DEF     = 64;
  localparam int PAGES_PER_PROC_DEF = 64;
  localparam int MAX_PROCS_DEF      = 8;

  localparam logic [31:0] AGE_TOP    = 32'h8000_0000;
  localparam logic [3:0]  NRU_PERIOD = 4'd10;

  // input func codes
  localparam logic [1:0] FN_SWITCH = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_WRITE  = 2'd2;

  // replacement policies
  localparam logic [2:0] POL_FIFO   = 3'd0;
  localparam logic [2:0] POL_SC     = 3'd1;
  localparam logic [2:0] POL_CLOCK  = 3'd2;
  localparam logic [2:0] POL_RANDOM = 3'd3;
  localparam logic [2:0] POL_NRU    = 3'd4;
  localparam logic [2:0] POL_AGING  = 3'd5;

  // result event codes
  localparam logic [3:0] EV_UNMAP   = 4'd0;
  localparam logic [3:0] EV_OUT     = 4'd1;
  localparam logic [3:0] EV_FOUT    = 4'd2;
  localparam logic [3:0] EV_IN      = 4'd3;
  localparam logic [3:0] EV_FIN     = 4'd4;
  localparam logic [3:0] EV_ZERO    = 4'd5;
  localparam logic [3:0] EV_MAP     = 4'd6;
  localparam logic [3:0] EV_SEGV    = 4'd7;
  localparam logic [3:0] EV_SEGPROT = 4'd8;
  localparam logic [3:0] EV_DONE    = 4'd9;

  // configuration register indexes
  localparam logic [0:0] REG_POLICY = 1'd0;
  localparam logic [0:0] REG_FRAMES = 1'd1;

  typedef struct packed {
    logic present;
    logic wprot;
    logic modified;
    logic referenced;
    logic pagedout;
    logic fmapped;
  } pte_t;

  typedef struct packed {
    logic [2:0] proc;
    logic [5:0] vpage;
  } owner_t;

endpackage

>>> hdl/page_fault_and_replacement_unit.sv
// Top level of the page fault and replacement unit.
`timescale 1ns / 1ps

// Handles one transaction at a time: a context switch or a read/write access
// to a page of the current process. Page flags and 32-bit aging counters sit
// in two synchronous memories of MAX_PROCS*PAGES_PER_PROC entries, the frame
// owners in a third memory of MAX_FRAMES entries; every step reads, modifies
// and writes back one entry. After reset a clearing pass over the
// MAX_PROCS*PAGES_PER_PROC entries (512 by default) zeroes the page table and
// the ages; no input transaction is taken until it ends, config writes are.
// A context switch or unused func gives only the done result; a hit checks
// write protection and sets the page flags; a miss to a free frame reads the
// page entry, fills the frame and maps it. An eviction adds a victim scan,
// then unmaps the victim (with a page-out result if it was modified). Scans:
// FIFO/clock step the hand over the frames (clock may go round twice); aging
// visits every frame in use; random takes the random value modulo the frame
// count in the serial remainder unit; NRU classifies every frame in use,
// picks the lowest class, draws a member with the remainder unit, then walks
// the frames up to it. A result stays in the output register until taken; up
// to six results per transaction, the last one flagged with last.

module page_fault_and_replacement_unit #(
  parameter int MAX_FRAMES     = pfru_pkg::MAX_FRAMES_DEF,
  parameter int PAGES_PER_PROC = pfru_pkg::PAGES_PER_PROC_DEF,
  parameter int MAX_PROCS      = pfru_pkg::MAX_PROCS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_proc_id,
  input  logic [5:0]  in_vpage,
  input  logic        in_in_area,
  input  logic        in_area_write_protect,
  input  logic        in_area_file_mapped,
  input  logic [30:0] in_random_value,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [2:0]  out_event_proc,
  output logic [5:0]  out_event_vpage,
  output logic [5:0]  out_event_frame,
  output logic        out_random_used,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int TS  = MAX_PROCS * PAGES_PER_PROC;
  localparam int AW  = (TS > 1) ? $clog2(TS) : 1;
  localparam int FW  = $clog2(MAX_FRAMES + 1);       // holds a frame count
  localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  localparam int NS = 29;
  typedef enum logic [NS-1:0] {
    S_CLEAR = NS'(1) << 0,
    S_IDLE  = NS'(1) << 1,
    S_LOOK  = NS'(1) << 2,
    S_SEGV  = NS'(1) << 3,
    S_DONE  = NS'(1) << 4,
    S_ACC   = NS'(1) << 5,
    S_FRD   = NS'(1) << 6,
    S_FWR   = NS'(1) << 7,
    S_MAP   = NS'(1) << 8,
    S_VO    = NS'(1) << 9,
    S_VP    = NS'(1) << 10,
    S_VU    = NS'(1) << 11,
    S_VOUT  = NS'(1) << 12,
    S_H0    = NS'(1) << 13,
    S_H1    = NS'(1) << 14,
    S_H2    = NS'(1) << 15,
    S_RND   = NS'(1) << 16,
    S_N1    = NS'(1) << 17,
    S_N2    = NS'(1) << 18,
    S_N3    = NS'(1) << 19,
    S_N4    = NS'(1) << 20,
    S_N5    = NS'(1) << 21,
    S_N6    = NS'(1) << 22,
    S_N7    = NS'(1) << 23,
    S_A1    = NS'(1) << 24,
    S_A2    = NS'(1) << 25,
    S_A3    = NS'(1) << 26,
    S_A4    = NS'(1) << 27,
    S_A5    = NS'(1) << 28
  } state_t;

  function automatic logic [AW-1:0] pt_addr(input logic [2:0] p, input logic [5:0] v);
    return AW'(int'(p) * PAGES_PER_PROC + int'(v));
  endfunction

  // ---------------------------------------------------------------- memories
  pfru_pkg::pte_t   pt_mem  [TS];
  logic [31:0]      age_mem [TS];
  pfru_pkg::owner_t own_mem [MAX_FRAMES];
  logic [2:0]       cls_mem [MAX_FRAMES];   // {present, R, M} of NRU scan

  pfru_pkg::pte_t   pt_q, pt_wd;
  logic [31:0]      age_q, age_wd;
  pfru_pkg::owner_t own_q, own_wd;
  logic [2:0]       cls_q, cls_wd;
  logic             pt_we, age_we, own_we, cls_we;
  logic [AW-1:0]    pt_wa, age_wa, pt_ra, pt_ra_r;
  logic [FIW-1:0]   own_wa, own_ra, own_ra_r, cls_wa, cls_ra;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_q <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_wa] <= age_wd;
    age_q <= age_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_wa] <= own_wd;
    own_q <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (cls_we) cls_mem[cls_wa] <= cls_wd;
    cls_q <= cls_mem[cls_ra];
  end

  // ---------------------------------------------------------------- registers
  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [2:0]       cur_r, cur_nxt;
  logic [2:0]       policy_r;
  logic [6:0]       fiu_r;
  logic [FW-1:0]    free_r, free_nxt;
  logic [FW-1:0]    hand_r, hand_nxt;
  logic [3:0]       evc_r, evc_nxt;
  logic             sc_r, sc_nxt;
  logic             rused_r, rused_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [5:0]       vp_r, vp_nxt;
  logic             wp_r, wp_nxt, fm_r, fm_nxt;
  logic             area_r, area_nxt;        // area flag of the latched transaction
  logic [30:0]      rnd_r, rnd_nxt;
  logic [AW-1:0]    ca_r, ca_nxt;           // page table address of the access
  logic [FIW-1:0]   f_r, f_nxt;             // frame being filled
  pfru_pkg::owner_t o_r, o_nxt;
  pfru_pkg::pte_t   pte_r, pte_nxt;
  logic [FW-1:0]    i_r, i_nxt, m_r, m_nxt, k_r, k_nxt;
  logic [FW-1:0]    cnt_r [4];
  logic [FW-1:0]    cnt_nxt [4];
  logic [1:0]       cs_r, cs_nxt;
  logic [31:0]      min_r, min_nxt;
  logic [FIW-1:0]   best_r, best_nxt;
  pfru_pkg::owner_t bo_r, bo_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       ev_res_r;
  logic [2:0]       ev_proc_r;
  logic [5:0]       ev_vpage_r, ev_frame_r;
  logic             ev_ru_r, ev_last_r;

  // result emission
  logic             can_load, emit, e_last;
  logic [3:0]       e_res;
  logic [2:0]       e_proc;
  logic [5:0]       e_vpage, e_frame;

  // remainder unit
  logic             div_start, div_done;
  logic [30:0]      div_dvd;
  logic [FW-1:0]    div_dvs, div_rem;

  // misc combinational
  logic [FW-1:0]    n_w;
  logic [FW-1:0]    h_w;
  logic [31:0]      na_w;
  logic [1:0]       c_w, sel_w;
  logic             found_w, scan_end;

  assign can_load = !out_valid_r || out_ready;

  // effective frame count
  always_comb begin
    if (fiu_r == 7'd0)                   n_w = FW'(1);
    else if (int'(fiu_r) > MAX_FRAMES)   n_w = FW'(MAX_FRAMES);
    else                                 n_w = FW'(fiu_r);
  end

  assign h_w      = (hand_r >= n_w) ? '0 : hand_r;
  assign na_w     = pt_q.referenced ? (pfru_pkg::AGE_TOP | (age_q >> 1)) : (age_q >> 1);
  assign c_w      = {pt_q.referenced, pt_q.modified};
  assign scan_end = ((i_r + FW'(1)) == n_w);
  assign cls_ra   = i_r[FIW-1:0];
  assign area_nxt = (state_r == S_IDLE && in_valid) ? in_in_area : area_r;

  // lowest non-empty NRU class
  always_comb begin
    sel_w   = 2'd0;
    found_w = 1'b0;
    for (int j = 3; j >= 0; j--) begin
      if (cnt_r[j] != '0) begin
        sel_w   = 2'(j);
        found_w = 1'b1;
      end
    end
  end

  pfru_mod #(.VW(FW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .rem      (div_rem)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    free_nxt  = free_r;
    hand_nxt  = hand_r;
    evc_nxt   = evc_r;
    sc_nxt    = sc_r;
    rused_nxt = rused_r;
    func_nxt  = func_r;
    vp_nxt    = vp_r;
    wp_nxt    = wp_r;
    fm_nxt    = fm_r;
    rnd_nxt   = rnd_r;
    ca_nxt    = ca_r;
    f_nxt     = f_r;
    o_nxt     = o_r;
    pte_nxt   = pte_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    for (int j = 0; j < 4; j++) cnt_nxt[j] = cnt_r[j];
    cs_nxt    = cs_r;
    min_nxt   = min_r;
    best_nxt  = best_r;
    bo_nxt    = bo_r;

    pt_ra  = pt_ra_r;
    own_ra = own_ra_r;
    pt_we  = 1'b0;
    pt_wa  = ca_r;
    pt_wd  = pt_q;
    age_we = 1'b0;
    age_wa = pt_addr(o_r.proc, o_r.vpage);
    age_wd = na_w;
    own_we = 1'b0;
    own_wa = f_r;
    own_wd = '{proc: cur_r, vpage: vp_r};
    cls_we = 1'b0;
    cls_wa = i_r[FIW-1:0];
    cls_wd = {pt_q.present, c_w};

    emit    = 1'b0;
    e_res   = pfru_pkg::EV_DONE;
    e_proc  = '0;
    e_vpage = '0;
    e_frame = '0;
    e_last  = 1'b0;

    div_start = 1'b0;
    div_dvd   = rnd_r;
    div_dvs   = n_w;

    in_ready = (state_r == S_IDLE);

    case (state_r)
      S_CLEAR: begin
        pt_we  = 1'b1;
        pt_wa  = clr_r;
        pt_wd  = '0;
        age_we = 1'b1;
        age_wa = clr_r;
        age_wd = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          vp_nxt    = in_vpage;
          wp_nxt    = in_area_write_protect;
          fm_nxt    = in_area_file_mapped;
          rnd_nxt   = in_random_value;
          rused_nxt = 1'b0;
          ca_nxt    = pt_addr(cur_r, in_vpage);
          if (in_func == pfru_pkg::FN_SWITCH) begin
            if (int'(in_proc_id) < MAX_PROCS) cur_nxt = in_proc_id;
            state_nxt = S_DONE;
          end else if (in_func == pfru_pkg::FN_READ || in_func == pfru_pkg::FN_WRITE) begin
            if (int'(in_vpage) >= PAGES_PER_PROC) begin
              state_nxt = S_SEGV;
            end else begin
              pt_ra     = pt_addr(cur_r, in_vpage);
              state_nxt = S_LOOK;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_LOOK: begin
        pte_nxt = pt_q;
        if (pt_q.present) begin
          state_nxt = S_ACC;
        end else if (!area_r) begin
          state_nxt = S_SEGV;
        end else if (free_r < n_w) begin
          f_nxt     = free_r[FIW-1:0];
          free_nxt  = free_r + FW'(1);
          state_nxt = S_FRD;
        end else begin
          evc_nxt = (evc_r + 4'd1 >= pfru_pkg::NRU_PERIOD) ? 4'd0 : evc_r + 4'd1;
          i_nxt   = '0;
          case (policy_r)
            pfru_pkg::POL_SC, pfru_pkg::POL_CLOCK: begin
              sc_nxt    = 1'b1;
              state_nxt = S_H0;
            end
            pfru_pkg::POL_RANDOM: begin
              rused_nxt = 1'b1;
              div_start = 1'b1;
              state_nxt = S_RND;
            end
            pfru_pkg::POL_NRU: begin
              rused_nxt = 1'b1;
              for (int j = 0; j < 4; j++) cnt_nxt[j] = '0;
              state_nxt = S_N1;
            end
            pfru_pkg::POL_AGING: begin
              min_nxt   = '1;
              best_nxt  = '0;
              bo_nxt    = '0;
              state_nxt = S_A1;
            end
            default: begin
              sc_nxt    = 1'b0;
              state_nxt = S_H0;
            end
          endcase
        end
      end

      S_SEGV: begin
        if (can_load) begin
          emit      = 1'b1;
          e_res     = pfru_pkg::EV_SEGV;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (can_load) begin
          emit      = 1'b1;
          e_res     = pfru_pkg::EV_DONE;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_ACC: begin
        pt_wd            = pte_r;
        pt_wd.referenced = 1'b1;
        if (func_r == pfru_pkg::FN_WRITE && pte_r.wprot) begin
          if (can_load) begin
            pt_we     = 1'b1;
            emit      = 1'b1;
            e_res     = pfru_pkg::EV_SEGPROT;
            state_nxt = S_DONE;
          end
        end else begin
          if (func_r == pfru_pkg::FN_WRITE) pt_wd.modified = 1'b1;
          pt_we     = 1'b1;
          state_nxt = S_DONE;
        end
      end

      // ---- bring the page in
      S_FRD: begin
        pt_ra     = ca_r;
        state_nxt = S_FWR;
      end

      S_FWR: begin
        if (can_load) begin
          pte_nxt          = pt_q;
          pte_nxt.present  = 1'b1;
          pte_nxt.wprot    = wp_r;
          pte_nxt.fmapped  = fm_r;
          pte_nxt.modified = 1'b0;
          own_we           = 1'b1;
          emit             = 1'b1;
          if (fm_r)              e_res = pfru_pkg::EV_FIN;
          else if (pt_q.pagedout) e_res = pfru_pkg::EV_IN;
          else                   e_res = pfru_pkg::EV_ZERO;
          state_nxt = S_MAP;
        end
      end

      S_MAP: begin
        if (can_load) begin
          emit      = 1'b1;
          e_res     = pfru_pkg::EV_MAP;
          e_frame   = 6'(f_r);
          state_nxt = S_ACC;
        end
      end

      // ---- unmap the victim in frame f_r
      S_VO: begin
        own_ra    = f_r;
        state_nxt = S_VP;
      end

      S_VP: begin
        o_nxt     = own_q;
        pt_ra     = pt_addr(own_q.proc, own_q.vpage);
        state_nxt = S_VU;
      end

      S_VU: begin
        if (can_load) begin
          pt_we         = 1'b1;
          pt_wa         = pt_addr(o_r.proc, o_r.vpage);
          pt_wd.present = 1'b0;
          if (pt_q.modified && !pt_q.fmapped) pt_wd.pagedout = 1'b1;
          pte_nxt = pt_q;
          emit    = 1'b1;
          e_res   = pfru_pkg::EV_UNMAP;
          e_proc  = o_r.proc;
          e_vpage = o_r.vpage;
          state_nxt = pt_q.modified ? S_VOUT : S_FRD;
        end
      end

      S_VOUT: begin
        if (can_load) begin
          emit      = 1'b1;
          e_res     = pte_r.fmapped ? pfru_pkg::EV_FOUT : pfru_pkg::EV_OUT;
          state_nxt = S_FRD;
        end
      end

      // ---- FIFO / second chance / clock
      S_H0: begin
        hand_nxt  = h_w;
        own_ra    = h_w[FIW-1:0];
        state_nxt = S_H1;
      end

      S_H1: begin
        o_nxt     = own_q;
        pt_ra     = pt_addr(own_q.proc, own_q.vpage);
        state_nxt = S_H2;
      end

      S_H2: begin
        hand_nxt = hand_r + FW'(1);
        if (sc_r && pt_q.referenced && pt_q.present) begin
          pt_we            = 1'b1;
          pt_wa            = pt_addr(o_r.proc, o_r.vpage);
          pt_wd.referenced = 1'b0;
          state_nxt        = S_H0;
        end else begin
          f_nxt     = hand_r[FIW-1:0];
          state_nxt = S_VO;
        end
      end

      // ---- random
      S_RND: begin
        if (div_done) begin
          f_nxt     = div_rem[FIW-1:0];
          state_nxt = S_VO;
        end
      end

      // ---- NRU: classify pass
      S_N1: begin
        own_ra    = i_r[FIW-1:0];
        state_nxt = S_N2;
      end

      S_N2: begin
        o_nxt     = own_q;
        pt_ra     = pt_addr(own_q.proc, own_q.vpage);
        state_nxt = S_N3;
      end

      S_N3: begin
        cls_we = 1'b1;
        for (int j = 0; j < 4; j++) begin
          if (pt_q.present && c_w == 2'(j)) cnt_nxt[j] = cnt_r[j] + FW'(1);
        end
        if (evc_r == 4'd0) begin
          pt_we            = 1'b1;
          pt_wa            = pt_addr(o_r.proc, o_r.vpage);
          pt_wd.referenced = 1'b0;
        end
        i_nxt     = i_r + FW'(1);
        state_nxt = scan_end ? S_N4 : S_N1;
      end

      S_N4: begin
        if (!found_w) begin
          f_nxt     = '0;
          state_nxt = S_VO;
        end else begin
          cs_nxt    = sel_w;
          div_start = 1'b1;
          div_dvs   = cnt_r[0];
          if (sel_w == 2'd1) div_dvs = cnt_r[1];
          if (sel_w == 2'd2) div_dvs = cnt_r[2];
          if (sel_w == 2'd3) div_dvs = cnt_r[3];
          state_nxt = S_N5;
        end
      end

      S_N5: begin
        if (div_done) begin
          k_nxt     = div_rem;
          i_nxt     = '0;
          m_nxt     = '0;
          state_nxt = S_N6;
        end
      end

      // ---- NRU: pick the k-th member of the chosen class
      S_N6: begin
        state_nxt = S_N7;
      end

      S_N7: begin
        i_nxt     = i_r + FW'(1);
        state_nxt = S_N6;
        if (cls_q == {1'b1, cs_r}) begin
          if (m_r == k_r) begin
            f_nxt     = i_r[FIW-1:0];
            state_nxt = S_VO;
          end else begin
            m_nxt = m_r + FW'(1);
          end
        end
      end

      // ---- aging: shift the counter of every frame in use, track the minimum
      S_A1: begin
        own_ra    = i_r[FIW-1:0];
        state_nxt = S_A2;
      end

      S_A2: begin
        o_nxt     = own_q;
        pt_ra     = pt_addr(own_q.proc, own_q.vpage);
        state_nxt = S_A3;
      end

      S_A3: begin
        age_we = 1'b1;
        if (pt_q.referenced) begin
          pt_we            = 1'b1;
          pt_wa            = pt_addr(o_r.proc, o_r.vpage);
          pt_wd.referenced = 1'b0;
        end
        // frame 0 seeds the minimum, and a tie keeps the lower frame
        if (i_r == '0 || na_w < min_r) begin
          min_nxt  = na_w;
          best_nxt = i_r[FIW-1:0];
          bo_nxt   = o_r;
        end
        i_nxt     = i_r + FW'(1);
        state_nxt = scan_end ? S_A4 : S_A1;
      end

      S_A4: begin
        age_we    = 1'b1;
        age_wa    = pt_addr(bo_r.proc, bo_r.vpage);
        age_wd    = '0;
        pt_ra     = pt_addr(bo_r.proc, bo_r.vpage);
        state_nxt = S_A5;
      end

      S_A5: begin
        pt_we            = 1'b1;
        pt_wa            = pt_addr(bo_r.proc, bo_r.vpage);
        pt_wd.referenced = 1'b0;
        f_nxt            = best_r;
        state_nxt        = S_VO;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      policy_r    <= pfru_pkg::POL_FIFO;
      fiu_r       <= 7'd64;
      free_r      <= '0;
      hand_r      <= '0;
      evc_r       <= '0;
      rused_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      free_r      <= free_nxt;
      hand_r      <= hand_nxt;
      evc_r       <= evc_nxt;
      rused_r     <= rused_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_index == pfru_pkg::REG_POLICY) policy_r <= cfg_data[2:0];
        else                                   fiu_r    <= cfg_data;
      end
    end
    pt_ra_r  <= pt_ra;
    own_ra_r <= own_ra;
    sc_r     <= sc_nxt;
    func_r   <= func_nxt;
    vp_r     <= vp_nxt;
    wp_r     <= wp_nxt;
    fm_r     <= fm_nxt;
    area_r   <= area_nxt;
    rnd_r    <= rnd_nxt;
    ca_r     <= ca_nxt;
    f_r      <= f_nxt;
    o_r      <= o_nxt;
    pte_r    <= pte_nxt;
    i_r      <= i_nxt;
    m_r      <= m_nxt;
    k_r      <= k_nxt;
    for (int j = 0; j < 4; j++) cnt_r[j] <= cnt_nxt[j];
    cs_r     <= cs_nxt;
    min_r    <= min_nxt;
    best_r   <= best_nxt;
    bo_r     <= bo_nxt;
    if (emit) begin
      ev_res_r   <= e_res;
      ev_proc_r  <= e_proc;
      ev_vpage_r <= e_vpage;
      ev_frame_r <= e_frame;
      ev_ru_r    <= rused_r;
      ev_last_r  <= e_last;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_event_res   = ev_res_r;
  assign out_event_proc  = ev_proc_r;
  assign out_event_vpage = ev_vpage_r;
  assign out_event_frame = ev_frame_r;
  assign out_random_used = ev_ru_r;
  assign out_last        = ev_last_r;

  // ---------------------------------------------------------------- checks
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transaction taken while busy");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(free_r) <= MAX_FRAMES) else $error("free frame count overflow");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r) else $error("result during clearing pass");

  a_last_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit && e_last |-> state_r == S_DONE) else $error("last flag outside done step");

endmodule

>>> hdl/pfru_mod.sv
// Bit-serial remainder unit: 31-bit dividend modulo a small divisor.
`timescale 1ns / 1ps

module pfru_mod #(
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [30:0]   dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [30:0]   dvd_r, dvd_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW:0]   shl;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    shl      = {rem_r, dvd_r[30]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // one quotient bit per cycle
      if (shl >= {1'b0, dvs_r}) rem_nxt = VW'(shl - {1'b0, dvs_r});
      else                      rem_nxt = VW'(shl);
      dvd_nxt = {dvd_r[29:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd30) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
